// ===== src/l2a_pkg.sv =====
// Shared constants, types and the character ramp for the luma to ASCII-art stream.
package l2a_pkg;

  localparam int MAX_WIDTH   = 62;
  localparam int MAX_HEIGHT  = 255;
  localparam int RAMP_LEN    = 93;
  localparam int LUMA_OFFSET = 16;
  localparam int LUMA_SPAN   = 219;
  localparam int LUMA_SCALE  = 110;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] DASH_CHAR    = 8'h2D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  // Register indexes of the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Ramp from dark to bright, as ASCII codes.
  localparam logic [7:0] RAMP [RAMP_LEN] = '{
    8'd32,  8'd32,  8'd96,  8'd46,  8'd45,  8'd39,  8'd58,  8'd95,  8'd44,  8'd94,
    8'd61,  8'd59,  8'd62,  8'd60,  8'd43,  8'd33,  8'd114, 8'd99,  8'd42,  8'd47,
    8'd122, 8'd63,  8'd115, 8'd108, 8'd116, 8'd118, 8'd41,  8'd106, 8'd55,  8'd40,
    8'd124, 8'd102, 8'd105, 8'd123, 8'd67,  8'd125, 8'd70,  8'd73,  8'd51,  8'd49,
    8'd84,  8'd76,  8'd117, 8'd91,  8'd110, 8'd101, 8'd111, 8'd90,  8'd53,  8'd89,
    8'd120, 8'd74,  8'd121, 8'd97,  8'd93,  8'd50,  8'd69,  8'd83,  8'd119, 8'd113,
    8'd107, 8'd80,  8'd54,  8'd104, 8'd57,  8'd100, 8'd52,  8'd86,  8'd112, 8'd79,
    8'd71,  8'd98,  8'd85,  8'd65,  8'd75,  8'd88,  8'd72,  8'd109, 8'd56,  8'd82,
    8'd68,  8'd35,  8'd36,  8'd66,  8'd103, 8'd48,  8'd77,  8'd78,  8'd87,  8'd81,
    8'd37,  8'd38,  8'd64
  };

  // One classified pixel, as handed from the front to the back.
  typedef struct packed {
    logic [7:0] glyph;
    logic       top;        // frame opens with this pixel: top border first
    logic       row_end;    // newline after the glyph
    logic       frame_end;  // bottom border after the newline
    logic [5:0] width;      // dashes per border line, at least one
  } cmd_t;

endpackage

// ===== src/l2a_front.sv =====
// Front end: configuration registers, raster counters and glyph lookup.
module l2a_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic            wr_index,
  input  logic [7:0]      wr_data,
  input  logic            accept,
  input  logic [7:0]      luma,
  output l2a_pkg::cmd_t   cmd
);
  import l2a_pkg::*;

  logic [5:0] width_in_use;
  logic [7:0] height_in_use;
  logic [5:0] column_count;
  logic [7:0] row_count;

  logic [5:0]  eff_w;
  logic [7:0]  eff_h;
  logic [7:0]  offset_v;
  logic [14:0] scaled;
  logic [6:0]  ramp_idx;
  logic        row_end;
  logic        frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= 6'd32;
      height_in_use <= 8'd32;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_WIDTH:  width_in_use  <= wr_data[5:0];
        REG_HEIGHT: height_in_use <= wr_data;
      endcase
    end
  end

  always_comb begin
    eff_w = width_in_use;
    if (width_in_use == 6'd0) eff_w = 6'd1;
    else if (width_in_use > 6'(MAX_WIDTH)) eff_w = 6'(MAX_WIDTH);
    eff_h = (height_in_use == 8'd0) ? 8'd1 : height_in_use;
  end

  always_comb begin
    if (luma < 8'(LUMA_OFFSET)) offset_v = 8'd0;
    else offset_v = luma - 8'(LUMA_OFFSET);
    if (offset_v > 8'(LUMA_SPAN)) offset_v = 8'(LUMA_SPAN);
    scaled   = 15'(offset_v) * 15'(LUMA_SCALE);
    ramp_idx = scaled[14:8];
    if (ramp_idx > 7'(RAMP_LEN - 1)) ramp_idx = 7'(RAMP_LEN - 1);
  end

  assign row_end   = column_count >= (eff_w - 6'd1);
  assign frame_end = row_end && (row_count >= (eff_h - 8'd1));

  always_comb begin
    cmd.glyph     = RAMP[ramp_idx];
    cmd.top       = (column_count == 6'd0) && (row_count == 8'd0);
    cmd.row_end   = row_end;
    cmd.frame_end = frame_end;
    cmd.width     = eff_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 6'd0;
      row_count    <= 8'd0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= 6'd0;
        row_count    <= frame_end ? 8'd0 : row_count + 8'd1;
      end else begin
        column_count <= column_count + 6'd1;
      end
    end
  end

endmodule

// ===== src/l2a_queue.sv =====
// Short command queue between the front end and the character sequencer.
module l2a_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  l2a_pkg::cmd_t   wr_cmd,
  output logic            full,
  input  logic            rd,
  output l2a_pkg::cmd_t   rd_cmd,
  output logic            nonempty
);
  import l2a_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/l2a_back.sv =====
// Back end: expands each command into characters and holds the output beat.
module l2a_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  l2a_pkg::cmd_t   cmd_in,
  output logic            cmd_take,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      character,
  output logic            last_of_item,
  output logic            end_of_frame
);
  import l2a_pkg::*;

  localparam logic [2:0] PH_TOP_DASH = 3'd0;
  localparam logic [2:0] PH_TOP_NL   = 3'd1;
  localparam logic [2:0] PH_GLYPH    = 3'd2;
  localparam logic [2:0] PH_ROW_NL   = 3'd3;
  localparam logic [2:0] PH_BOT_DASH = 3'd4;

  cmd_t       cur;
  logic       busy;
  logic [2:0] phase;
  logic [5:0] dash_cnt;
  logic       out_valid;
  logic       emit;

  logic [7:0] ch_next;
  logic       last_next;
  logic       eof_next;
  logic       done_next;
  logic [2:0] phase_next;
  logic       dash_last;

  assign empty     = !out_valid;
  assign emit      = busy && (!out_valid || pop);
  assign cmd_take  = !busy && cmd_valid;
  assign dash_last = dash_cnt == (cur.width - 6'd1);

  always_comb begin
    ch_next    = DASH_CHAR;
    last_next  = 1'b0;
    eof_next   = 1'b0;
    done_next  = 1'b0;
    phase_next = phase;
    unique case (phase)
      PH_TOP_DASH: begin
        if (dash_last) phase_next = PH_TOP_NL;
      end
      PH_TOP_NL: begin
        ch_next    = NEWLINE_CHAR;
        phase_next = PH_GLYPH;
      end
      PH_GLYPH: begin
        ch_next    = cur.glyph;
        last_next  = !cur.row_end;
        done_next  = !cur.row_end;
        phase_next = PH_ROW_NL;
      end
      PH_ROW_NL: begin
        ch_next    = NEWLINE_CHAR;
        last_next  = !cur.frame_end;
        done_next  = !cur.frame_end;
        phase_next = PH_BOT_DASH;
      end
      PH_BOT_DASH: begin
        last_next = dash_last;
        eof_next  = dash_last;
        done_next = dash_last;
      end
      default: begin
        done_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd_in;
    if (emit) begin
      character    <= ch_next;
      last_of_item <= last_next;
      end_of_frame <= eof_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_GLYPH;
      dash_cnt  <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;

      if (cmd_take) begin
        busy     <= 1'b1;
        phase    <= cmd_in.top ? PH_TOP_DASH : PH_GLYPH;
        dash_cnt <= 6'd0;
      end else if (emit) begin
        if (done_next) busy <= 1'b0;
        // Dash runs count up inside a phase and restart when the phase moves on.
        if (phase_next != phase) dash_cnt <= 6'd0;
        else dash_cnt <= dash_cnt + 6'd1;
        phase <= phase_next;
      end
    end
  end

endmodule

// ===== src/luma_to_ascii_art_stream.sv =====
// Top level of the luma to ASCII-art character stream.
// Luma pixels enter on the push/full side in raster order and come out as ASCII characters on
// the empty/pop side, one character per beat. The character sequencer loads each pixel's
// command from the four-deep queue and then emits its glyph; a pixel that ends a row also
// emits a newline. The top border adds one dash per column plus its newline, and the bottom
// border adds one dash per column. The front end accepts a pixel every cycle until the queue
// fills, so short bursts pass at full speed while the sequencer drains border runs.
// width_in_use and height_in_use are to be written through wr_en/wr_index/wr_data only while
// the block is idle; the block itself does not enforce this. A width of 0 acts as 1
// and a width of 63 acts as 62, a height of 0 acts as 1.
module luma_to_ascii_art_stream (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [7:0] wr_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] luma,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] character,
  output logic       last_of_item,
  output logic       end_of_frame
);
  import l2a_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic accept;
  logic head_valid;
  logic head_take;

  assign accept = push && !full;

  l2a_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .accept   (accept),
    .luma     (luma),
    .cmd      (front_cmd)
  );

  l2a_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd       (head_take),
    .rd_cmd   (head_cmd),
    .nonempty (head_valid)
  );

  l2a_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd_in       (head_cmd),
    .cmd_take     (head_take),
    .empty        (empty),
    .pop          (pop),
    .character    (character),
    .last_of_item (last_of_item),
    .end_of_frame (end_of_frame)
  );

endmodule

// ===== src/l2a_checker.sv =====
// Port-level checks for the luma to ASCII-art stream, bound to the top level.
module l2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] character,
  input logic       last_of_item,
  input logic       end_of_frame
);
  import l2a_pkg::*;

  // Nothing is waiting to be taken right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("output not empty or input full after reset");

  // The frame text ends on the last character of a pixel.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> last_of_item)
    else $error("end_of_frame without last_of_item");

  // The frame text always closes with a bottom border dash.
  a_eof_dash: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> (character == DASH_CHAR))
    else $error("end_of_frame on a character other than a dash");

  // A beat that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(character) && $stable(last_of_item)
                          && $stable(end_of_frame)))
    else $error("waiting beat changed before it was taken");

endmodule

bind luma_to_ascii_art_stream l2a_checker u_l2a_checker (.*);
